### design/size_class_free_list_cache_top_macros.svh
// assertion macros for the size class free list cache
// used by the controller and the datapath, no other dependencies
`ifndef SIZE_CLASS_FREE_LIST_CACHE_TOP_MACROS_SVH
`define SIZE_CLASS_FREE_LIST_CACHE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SCFLC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scflc assertion failed");
// next-cycle implication, checked outside reset
`define SCFLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scflc assertion failed");
`else
`define SCFLC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCFLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/scflc_pkg.sv
// shared types, constants and codes of the size class free list cache
// no dependencies
`default_nettype none

package scflc_pkg;

   localparam int NUM_BUCKETS      = 16;
   localparam int STACK_DEPTH      = 8;
   localparam int MIN_BUCKET_SHIFT = 12;

   localparam int ADDR_W  = 48;
   localparam int COUNT_W = 32;
   localparam int BYTES_W = 56;

   localparam int BKT_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_BUCKETS * STACK_DEPTH;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_REPLY = 2'd2;

   typedef enum logic [2:0] {
      ACT_CACHE_GRANT = 3'd0,
      ACT_BACK_REQ    = 3'd1,
      ACT_BACK_GRANT  = 3'd2,
      ACT_FAILED      = 3'd3,
      ACT_CACHED      = 3'd4,
      ACT_RELEASE     = 3'd5,
      ACT_IGNORED     = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASS,
      ST_EXEC,
      ST_PEAK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [ADDR_W-1:0] size_bytes;
      logic [ADDR_W-1:0] address;
      logic              backing_ok;
   } req_type;

   typedef struct packed {
      action_type         action;
      logic [ADDR_W-1:0]  address_res;
      logic [ADDR_W-1:0]  block_size;
      logic               oversized;
      logic               underflow;
      logic [COUNT_W-1:0] live_allocs;
      logic [BYTES_W-1:0] live_bytes;
      logic [BYTES_W-1:0] peak_bytes;
   } rsp_type;

   typedef struct packed {
      logic load_in;
      logic classify;
      logic exec;
      logic finish;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### design/scflc_ram.sv
// generic single write port ram with a registered read port
// no dependencies
`default_nettype none

module scflc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/scflc_dp.sv
// datapath: size classification, bucket stacks, live counters, result register
// depends on scflc_pkg, scflc_ram and the assertion macro header
`default_nettype none
`include "size_class_free_list_cache_top_macros.svh"

module scflc_dp import scflc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   localparam logic [ADDR_W-1:0] SMALL_LIMIT = ADDR_W'(1) << MIN_BUCKET_SHIFT;

   function automatic logic [6:0] bit_len(input logic [ADDR_W-1:0] v);
      logic [6:0] w;
      w = 7'd0;
      for (int i = 0; i < ADDR_W; i++) begin
         if (v[i]) w = 7'(i + 1);
      end
      return w;
   endfunction

   // captured item
   req_type            in_ff;
   logic [ADDR_W-1:0]  m_ff;
   logic               small_ff;

   // classification
   logic [BKT_W-1:0]   idx_ff,   idx_in;
   logic [ADDR_W-1:0]  block_ff, block_in;
   logic               over_ff,  over_in;
   logic [6:0]         width;
   logic [6:0]         wide_idx;

   // persistent state
   logic [FILL_W-1:0]  fill_ff [NUM_BUCKETS];
   logic [COUNT_W-1:0] live_count_ff;
   logic [BYTES_W-1:0] live_total_ff;
   logic [BYTES_W-1:0] peak_ff;
   logic               pend_valid_ff;
   logic [ADDR_W-1:0]  pend_block_ff;
   logic               pend_over_ff;

   // step result
   action_type         act_ff,   act_in;
   logic [ADDR_W-1:0]  raddr_ff, raddr_in;
   logic [ADDR_W-1:0]  rblock_ff, rblock_in;
   logic               rover_ff, rover_in;
   logic               runder_ff, runder_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // exec decisions
   logic [FILL_W-1:0]  fill_cur;
   logic               hit;
   logic               under;
   logic [ADDR_W-1:0]  add_block;
   logic [BYTES_W:0]   sum_total;
   logic [BYTES_W:0]   diff_total;
   logic [BYTES_W-1:0] sat_total;
   logic [COUNT_W-1:0] cnt_inc;
   logic               do_push, do_pop, do_add, do_sub, set_pend, clr_pend;
   logic [MEM_AW-1:0]  mem_base;
   logic [ADDR_W-1:0]  ram_rd;

   always_comb begin
      width    = bit_len(m_ff);
      wide_idx = width - 7'(MIN_BUCKET_SHIFT);
      if (small_ff) begin
         idx_in   = '0;
         block_in = SMALL_LIMIT;
         over_in  = 1'b0;
      end else if ((32'(wide_idx) >= NUM_BUCKETS) || (width >= 7'(ADDR_W))) begin
         idx_in   = '0;
         block_in = in_ff.size_bytes;
         over_in  = 1'b1;
      end else begin
         idx_in   = BKT_W'(wide_idx);
         block_in = ADDR_W'(1) << width;
         over_in  = 1'b0;
      end
   end

   assign fill_cur   = fill_ff[idx_ff];
   assign hit        = !over_ff && (fill_cur != '0) && (fill_cur <= FILL_W'(STACK_DEPTH));
   assign add_block  = (in_ff.func == FUNC_REPLY) ? pend_block_ff : block_ff;
   assign sum_total  = {1'b0, live_total_ff} + (BYTES_W + 1)'(add_block);
   assign sat_total  = (sum_total >= (BYTES_W + 1)'(BYTES_MAX)) ? BYTES_MAX
                                                                : sum_total[BYTES_W-1:0];
   assign diff_total = {1'b0, live_total_ff} - (BYTES_W + 1)'(block_ff);
   // borrow out means live bytes fall short of the block
   assign under      = (live_count_ff == '0) || diff_total[BYTES_W];
   assign cnt_inc    = (live_count_ff == COUNT_MAX) ? live_count_ff : live_count_ff + 1'b1;
   assign mem_base   = MEM_AW'(32'(idx_ff) * STACK_DEPTH);

   always_comb begin
      act_in    = ACT_IGNORED;
      raddr_in  = '0;
      rblock_in = '0;
      rover_in  = 1'b0;
      runder_in = 1'b0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      do_add    = 1'b0;
      do_sub    = 1'b0;
      set_pend  = 1'b0;
      clr_pend  = 1'b0;
      case (in_ff.func)
         FUNC_ALLOC: begin
            if (!pend_valid_ff) begin
               rblock_in = block_ff;
               if (hit) begin
                  act_in = ACT_CACHE_GRANT;
                  do_pop = 1'b1;
                  do_add = 1'b1;
               end else begin
                  act_in   = ACT_BACK_REQ;
                  rover_in = over_ff;
                  set_pend = 1'b1;
               end
            end
         end
         FUNC_FREE: begin
            if (in_ff.address != '0) begin
               raddr_in  = in_ff.address;
               rblock_in = block_ff;
               do_sub    = !under;
               if (!over_ff && !under && (fill_cur < FILL_W'(STACK_DEPTH))) begin
                  act_in  = ACT_CACHED;
                  do_push = 1'b1;
               end else begin
                  act_in    = ACT_RELEASE;
                  rover_in  = over_ff;
                  runder_in = under;
               end
            end
         end
         FUNC_REPLY: begin
            if (pend_valid_ff) begin
               clr_pend  = 1'b1;
               rblock_in = pend_block_ff;
               rover_in  = pend_over_ff;
               if (in_ff.backing_ok && (in_ff.address != '0)) begin
                  act_in   = ACT_BACK_GRANT;
                  raddr_in = in_ff.address;
                  do_add   = 1'b1;
               end else begin
                  act_in = ACT_FAILED;
               end
            end
         end
         default: begin
            act_in = ACT_IGNORED;
         end
      endcase
   end

   scflc_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MEM_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && do_push),
      .wr_addr (mem_base + MEM_AW'(fill_cur)),
      .wr_data (in_ff.address),
      .rd_en   (cmd.exec && do_pop),
      .rd_addr (mem_base + MEM_AW'(fill_cur - 1'b1)),
      .rd_data (ram_rd)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff    <= req_data;
         m_ff     <= (req_data.size_bytes == '0) ? '0 : req_data.size_bytes - 1'b1;
         small_ff <= req_data.size_bytes <= SMALL_LIMIT;
      end
      if (cmd.classify) begin
         idx_ff   <= idx_in;
         block_ff <= block_in;
         over_ff  <= over_in;
      end
      if (cmd.exec) begin
         act_ff    <= act_in;
         raddr_ff  <= raddr_in;
         rblock_ff <= rblock_in;
         rover_ff  <= rover_in;
         runder_ff <= runder_in;
      end
      if (cmd.exec && set_pend) begin
         pend_block_ff <= block_ff;
         pend_over_ff  <= over_ff;
      end
      // popped address arrives from the ram in the cycle after the read
      if (cmd.finish && (act_ff == ACT_CACHE_GRANT)) begin
         raddr_ff <= ram_rd;
      end
      if (cmd.load_out) begin
         rsp_data_ff.action      <= act_ff;
         rsp_data_ff.address_res <= raddr_ff;
         rsp_data_ff.block_size  <= rblock_ff;
         rsp_data_ff.oversized   <= rover_ff;
         rsp_data_ff.underflow   <= runder_ff;
         rsp_data_ff.live_allocs <= live_count_ff;
         rsp_data_ff.live_bytes  <= live_total_ff;
         rsp_data_ff.peak_bytes  <= peak_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
         live_count_ff <= '0;
         live_total_ff <= '0;
         peak_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.exec) begin
            if (do_push) fill_ff[idx_ff] <= fill_cur + 1'b1;
            if (do_pop)  fill_ff[idx_ff] <= fill_cur - 1'b1;
            if (do_add) begin
               live_count_ff <= cnt_inc;
               live_total_ff <= sat_total;
            end
            if (do_sub) begin
               live_count_ff <= live_count_ff - 1'b1;
               live_total_ff <= diff_total[BYTES_W-1:0];
            end
            if (set_pend) pend_valid_ff <= 1'b1;
            if (clr_pend) pend_valid_ff <= 1'b0;
         end
         if (cmd.finish && (live_total_ff > peak_ff)) begin
            peak_ff <= live_total_ff;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // bucket index is only meaningful once the beat has been classified
   `SCFLC_ASSERT_IMPL(a_fill_range, clock, reset, cmd.exec, fill_cur <= FILL_W'(STACK_DEPTH))
   `SCFLC_ASSERT_NEXT(a_peak_above_live, clock, reset, cmd.finish, peak_ff >= live_total_ff)
   `SCFLC_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)

endmodule

`default_nettype wire

### design/scflc_ctrl.sv
// controller: sequences one beat through classify, execute, peak and result load
// depends on scflc_pkg and the assertion macro header
`default_nettype none
`include "size_class_free_list_cache_top_macros.svh"

module scflc_ctrl import scflc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CLASS;
         ST_CLASS: state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_PEAK;
         ST_PEAK:  state_in = ST_DONE;
         ST_DONE:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_CLASS: cmd.classify = 1'b1;
         ST_EXEC:  cmd.exec     = 1'b1;
         ST_PEAK:  cmd.finish   = 1'b1;
         ST_DONE:  cmd.load_out = status.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `SCFLC_ASSERT_NEXT(a_accept_to_class, clock, reset, req_valid && req_ready, state_ff == ST_CLASS)
   `SCFLC_ASSERT_NEXT(a_exec_to_peak, clock, reset, cmd.exec, cmd.finish)

endmodule

`default_nettype wire

### design/size_class_free_list_cache_top.sv
// a request beat, once accepted, passes the classify, exec, peak and done states and its
// result is loaded on leaving done; a new request is taken only once done is left; the
// controller walks classify, stack read-modify-write, peak update and result load
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active high) empties all bucket stacks, clears the counters
// and the pending backing request; stack ram contents stay undefined until written
`default_nettype none

module size_class_free_list_cache_top import scflc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   scflc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scflc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/size_class_free_list_cache_checker.sv
// checker for the size class free list cache: predicts every result beat and compares it
// depends on scflc_pkg for the beat types, action codes and sizes
`timescale 1ns / 1ps

module size_class_free_list_cache_checker import scflc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           outstanding,
   output int           active_beats,
   output int           checked_beats
);

   logic [ADDR_W-1:0]  stack_mem [NUM_BUCKETS*STACK_DEPTH];
   int                 stack_top [NUM_BUCKETS];
   logic [COUNT_W-1:0] live_cnt;
   logic [BYTES_W-1:0] live_sum;
   logic [BYTES_W-1:0] peak_sum;
   logic               backing_wait;
   int                 wait_bucket;
   logic [ADDR_W-1:0]  wait_block;
   rsp_type            outcome_q [$];
   rsp_type            want;
   rsp_type            newest;

   // bucket index, NUM_BUCKETS when the size bypasses the cache
   function automatic void classify_size(input logic [ADDR_W-1:0] size, output int bucket,
                                         output logic [ADDR_W-1:0] blk);
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] m;
      int                width;
      s = (size == '0) ? ADDR_W'(1) : size;
      if (s <= (ADDR_W'(1) << MIN_BUCKET_SHIFT)) begin
         bucket = 0;
         blk    = ADDR_W'(1) << MIN_BUCKET_SHIFT;
         return;
      end
      m     = s - 1;
      width = 0;
      for (int i = 0; i < ADDR_W; i++) begin
         if (m[i]) width = i + 1;
      end
      bucket = width - MIN_BUCKET_SHIFT;
      if (bucket >= NUM_BUCKETS || width >= ADDR_W) begin
         bucket = NUM_BUCKETS;
         blk    = s;
      end else begin
         blk = ADDR_W'(1) << width;
      end
   endfunction

   function automatic void book_alloc(input logic [ADDR_W-1:0] blk);
      if (live_cnt != COUNT_MAX) live_cnt++;
      if (BYTES_W'(blk) >= BYTES_MAX - live_sum) live_sum = BYTES_MAX;
      else live_sum = live_sum + BYTES_W'(blk);
      if (live_sum > peak_sum) peak_sum = live_sum;
   endfunction

   function automatic rsp_type cache_outcome(input req_type r);
      rsp_type           o;
      int                bucket;
      logic [ADDR_W-1:0] blk;
      logic              big;
      logic              too_few;
      o        = '0;
      o.action = ACT_IGNORED;
      case (r.func)
         FUNC_ALLOC: if (!backing_wait) begin
            classify_size(r.size_bytes, bucket, blk);
            big = bucket >= NUM_BUCKETS;
            if (!big && stack_top[bucket] > 0) begin
               stack_top[bucket]--;
               o.address_res = stack_mem[bucket*STACK_DEPTH + stack_top[bucket]];
               o.block_size  = blk;
               o.action      = ACT_CACHE_GRANT;
               book_alloc(blk);
            end else begin
               backing_wait = 1'b1;
               wait_bucket  = bucket;
               wait_block   = blk;
               o.action     = ACT_BACK_REQ;
               o.block_size = blk;
               o.oversized  = big;
            end
         end
         FUNC_FREE: if (r.address != '0) begin
            classify_size(r.size_bytes, bucket, blk);
            big     = bucket >= NUM_BUCKETS;
            too_few = (live_cnt == '0) || (live_sum < BYTES_W'(blk));
            if (!too_few) begin
               live_cnt--;
               live_sum = live_sum - BYTES_W'(blk);
            end
            o.address_res = r.address;
            o.block_size  = blk;
            if (!big && !too_few && stack_top[bucket] < STACK_DEPTH) begin
               stack_mem[bucket*STACK_DEPTH + stack_top[bucket]] = r.address;
               stack_top[bucket]++;
               o.action = ACT_CACHED;
            end else begin
               o.action    = ACT_RELEASE;
               o.oversized = big;
               o.underflow = too_few;
            end
         end
         FUNC_REPLY: if (backing_wait) begin
            backing_wait = 1'b0;
            o.block_size = wait_block;
            o.oversized  = wait_bucket >= NUM_BUCKETS;
            // a grant of address zero counts as a failed backing allocation
            if (r.backing_ok && r.address != '0) begin
               book_alloc(wait_block);
               o.action      = ACT_BACK_GRANT;
               o.address_res = r.address;
            end else begin
               o.action = ACT_FAILED;
            end
         end
         default: ;
      endcase
      o.live_allocs = live_cnt;
      o.live_bytes  = live_sum;
      o.peak_bytes  = peak_sum;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) stack_top[i] = 0;
         live_cnt     = '0;
         live_sum     = '0;
         peak_sum     = '0;
         backing_wait = 1'b0;
         wait_bucket  = 0;
         wait_block   = '0;
         outcome_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat at %0t: act %0d addr %h", $realtime,
                           rsp_data.action, rsp_data.address_res);
            end else begin
               want = outcome_q.pop_front();
               checked_beats++;
               if (rsp_data.action !== want.action || rsp_data.address_res !== want.address_res
                   || rsp_data.block_size !== want.block_size
                   || rsp_data.oversized !== want.oversized
                   || rsp_data.underflow !== want.underflow
                   || rsp_data.live_allocs !== want.live_allocs
                   || rsp_data.live_bytes !== want.live_bytes
                   || rsp_data.peak_bytes !== want.peak_bytes) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch on result %0d: exp act %0d addr %h blk %h ovr %b und %b",
                              checked_beats, want.action, want.address_res, want.block_size,
                              want.oversized, want.underflow);
                     $display("   exp live %0d bytes %h peak %h", want.live_allocs,
                              want.live_bytes, want.peak_bytes);
                     $display("   got act %0d addr %h blk %h ovr %b und %b", rsp_data.action,
                              rsp_data.address_res, rsp_data.block_size, rsp_data.oversized,
                              rsp_data.underflow);
                     $display("   got live %0d bytes %h peak %h", rsp_data.live_allocs,
                              rsp_data.live_bytes, rsp_data.peak_bytes);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            newest = cache_outcome(req_data);
            outcome_q.insert(outcome_q.size(), newest);
            if (newest.action != ACT_IGNORED) active_beats++;
         end
         outstanding = outcome_q.size();
      end
   end

endmodule

### tb/tb_size_class_free_list_cache_top.sv
// testbench top for the size class free list cache: clock, reset, request and result stimulus
// depends on scflc_pkg, the block and size_class_free_list_cache_checker
`timescale 1ns / 1ps

module tb_size_class_free_list_cache_top;
   import scflc_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         STALL_CYCLES = 300;
   localparam logic [ADDR_W-1:0] ADDR_ALL = {ADDR_W{1'b1}};

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] blk;
      logic              big;
   } grant_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int active_beats;
   int checked_beats;

   int send_idle_pct;
   int ready_idle_pct;
   int free_pct;
   int loop_no;
   int sent_beats;
   int stall_requests;
   int stall_seen;
   int cache_hits;
   int stack_pushes;
   int releases;
   int failed_allocs;

   grant_type live_pool [$];
   grant_type granted;

   size_class_free_list_cache_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   size_class_free_list_cache_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .active_beats  (active_beats),
      .checked_beats (checked_beats)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, outstanding);
      $display("Test completed with failures");
      $finish;
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != stall_seen) begin
            stall_seen = stall_requests;
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
      end
   end

   // granted blocks become candidates for later frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_data.action)
            ACT_CACHE_GRANT, ACT_BACK_GRANT: begin
               if (rsp_data.action == ACT_CACHE_GRANT) cache_hits++;
               granted.addr = rsp_data.address_res;
               granted.blk  = rsp_data.block_size;
               granted.big  = rsp_data.oversized;
               live_pool.insert(live_pool.size(), granted);
               if (live_pool.size() > 256) void'(live_pool.pop_front());
            end
            ACT_CACHED:  stack_pushes++;
            ACT_RELEASE: releases++;
            ACT_FAILED:  failed_allocs++;
            default: ;
         endcase
      end
   end

   function automatic logic [ADDR_W-1:0] rand48();
      logic [31:0] hi;
      logic [31:0] lo;
      hi = $urandom;
      lo = $urandom;
      return {hi[ADDR_W-33:0], lo};
   endfunction

   // mostly the first few buckets so the stacks fill, hit and overflow
   function automatic logic [ADDR_W-1:0] pick_size();
      int unsigned roll;
      int unsigned b;
      int unsigned span;
      roll = $urandom_range(0, 99);
      if (roll < 90) begin
         b = (roll < 70) ? $urandom_range(0, 3) : $urandom_range(4, NUM_BUCKETS - 1);
         if (b == 0) return ADDR_W'($urandom_range(0, 1 << MIN_BUCKET_SHIFT));
         span = 1 << (MIN_BUCKET_SHIFT - 1 + b);
         return ADDR_W'(span) + ADDR_W'($urandom_range(1, span));
      end
      if (roll < 93) return ADDR_ALL;
      return rand48();
   endfunction

   function automatic req_type make_req(input logic [1:0] f, input logic [ADDR_W-1:0] sz,
                                        input logic [ADDR_W-1:0] ad, input logic ok);
      req_type r;
      r.func       = f;
      r.size_bytes = sz;
      r.address    = ad;
      r.backing_ok = ok;
      return r;
   endfunction

   // entered and left at a falling edge; valid stays up until the next call or pause
   task automatic send_beat(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_beats++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   // allocation followed by a backing reply; the reply is dropped if the cache hit
   task automatic alloc_and_reply(input logic [ADDR_W-1:0] size, input logic sure);
      logic [ADDR_W-1:0] grant_addr;
      logic              ok;
      send_beat(make_req(FUNC_ALLOC, size, rand48(), 1'($urandom_range(0, 1))));
      ok         = sure || ($urandom_range(0, 9) != 0);
      grant_addr = (!sure && $urandom_range(0, 15) == 0) ? '0 : rand48();
      if (grant_addr == '0 && sure) grant_addr = ADDR_W'(1);
      send_beat(make_req(FUNC_REPLY, rand48(), grant_addr, ok));
   endtask

   task automatic run_random(input int goal);
      int unsigned       roll;
      int unsigned       pick;
      grant_type         g;
      logic [ADDR_W-1:0] sz;
      while (active_beats < goal) begin
         if (loop_no % 32 == 0) free_pct = $urandom_range(15, 70);
         loop_no++;
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            case ($urandom_range(0, 4))
               0: send_beat(make_req(FUNC_FREE, pick_size(), rand48(),
                                     1'($urandom_range(0, 1))));
               1: send_beat(make_req(FUNC_REPLY, rand48(), rand48(),
                                     1'($urandom_range(0, 1))));
               2: send_beat(make_req(FUNC_UNUSED, rand48(), rand48(),
                                     1'($urandom_range(0, 1))));
               3: send_beat(make_req(FUNC_FREE, rand48(), '0, 1'($urandom_range(0, 1))));
               default: send_beat(make_req(FUNC_ALLOC, pick_size(), rand48(), 1'b1));
            endcase
         end else if (roll < 10 + free_pct && live_pool.size() > 0) begin
            pick = $urandom_range(0, live_pool.size() - 1);
            g    = live_pool[pick];
            live_pool.delete(pick);
            // any size that rounds to the same block
            if (g.big) sz = g.blk;
            else if (g.blk <= (ADDR_W'(1) << MIN_BUCKET_SHIFT))
               sz = ADDR_W'($urandom_range(0, 1 << MIN_BUCKET_SHIFT));
            else sz = g.blk - ADDR_W'($urandom_range(0, g.blk[31:0] / 2 - 1));
            send_beat(make_req(FUNC_FREE, sz, g.addr, 1'($urandom_range(0, 1))));
         end else begin
            alloc_and_reply(pick_size(), 1'b0);
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 14;
      ready_idle_pct = 82;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner cases, counters start from zero
      send_beat(make_req(FUNC_REPLY, '0, 48'h0000_1234_5000, 1'b1));
      send_beat(make_req(FUNC_FREE, 48'd4096, '0, 1'b0));
      send_beat(make_req(FUNC_FREE, 48'd4096, 48'h0000_0000_1000, 1'b0));
      send_beat(make_req(FUNC_UNUSED, ADDR_ALL, ADDR_ALL, 1'b1));
      send_beat(make_req(FUNC_ALLOC, '0, '0, 1'b0));
      send_beat(make_req(FUNC_ALLOC, 48'd100, '0, 1'b0));
      send_beat(make_req(FUNC_REPLY, '0, 48'h0000_00AB_C000, 1'b1));
      send_beat(make_req(FUNC_FREE, 48'd8192, 48'h0000_0000_9000, 1'b0));
      send_beat(make_req(FUNC_ALLOC, 48'd4097, '0, 1'b0));
      send_beat(make_req(FUNC_REPLY, '0, '0, 1'b1));
      send_beat(make_req(FUNC_ALLOC, 48'h0000_0800_0000, '0, 1'b0));
      send_beat(make_req(FUNC_REPLY, '0, 48'h0000_0000_7000, 1'b0));
      send_beat(make_req(FUNC_ALLOC, 48'h0000_0800_0001, '0, 1'b0));
      send_beat(make_req(FUNC_REPLY, '0, ADDR_ALL, 1'b1));
      send_beat(make_req(FUNC_FREE, 48'h0000_0800_0001, ADDR_ALL, 1'b0));
      send_beat(make_req(FUNC_ALLOC, ADDR_ALL, '0, 1'b0));
      send_beat(make_req(FUNC_REPLY, '0, 48'h8000_0000_0000, 1'b1));
      send_beat(make_req(FUNC_FREE, 48'd4096, 48'h0000_0000_5000, 1'b0));
      send_beat(make_req(FUNC_ALLOC, 48'd1, '0, 1'b0));
      send_beat(make_req(FUNC_FREE, 48'd1, 48'h0000_0000_6000, 1'b0));
      send_beat(make_req(FUNC_FREE, 48'd8192, 48'h0000_0000_8000, 1'b0));
      send_beat(make_req(FUNC_FREE, 48'd4096, 48'h0000_0000_7000, 1'b0));
      send_beat(make_req(FUNC_ALLOC, 48'd8192, '0, 1'b0));
      send_beat(make_req(FUNC_REPLY, '0, 48'h0000_0000_a000, 1'b1));

      run_random(350);
      drain_results();
      run_random(700);
      drain_results();

      send_idle_pct  = 82;
      ready_idle_pct = 14;
      run_random(1300);
      drain_results();

      // no idling; a long result stall lets the block back up into its input
      send_idle_pct  = 0;
      ready_idle_pct = 0;
      stall_requests++;
      run_random(1450);
      // enough huge grants to saturate live bytes
      repeat (270) alloc_and_reply(ADDR_ALL, 1'b1);
      run_random(2000);

      drain_results();
      repeat (20) @(negedge clock);

      $display("run covered %0d request beats (%0d with effect), %0d results checked",
               sent_beats, active_beats, checked_beats);
      $display("cache hits %0d, stack pushes %0d, backing releases %0d, failed allocs %0d",
               cache_hits, stack_pushes, releases, failed_allocs);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/scflc_pkg.sv
design/scflc_ram.sv
design/scflc_dp.sv
design/scflc_ctrl.sv
design/size_class_free_list_cache_top.sv
tb/size_class_free_list_cache_checker.sv
tb/tb_size_class_free_list_cache_top.sv
